// File: src/tbfs_pkg.sv
// Shared types and constants of the timed burst fire sequencer.
package tbfs_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned SpanW  = 16;
    localparam int unsigned ShotW  = 8;
    localparam int unsigned KeyW   = 16;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;

    // Register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] REG_PREHEAT_TIME = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_FEED_TIME    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_GAP_TIME     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_COOL_TIME    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SHOT_LIMIT   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_TRIGGER_MASK = 3'd5;

    // Reset values of the registers
    localparam logic [SpanW-1:0] RST_PREHEAT_TIME = 16'd200;
    localparam logic [SpanW-1:0] RST_FEED_TIME    = 16'd80;
    localparam logic [SpanW-1:0] RST_GAP_TIME     = 16'd180;
    localparam logic [SpanW-1:0] RST_COOL_TIME    = 16'd120;
    localparam logic [ShotW-1:0] RST_SHOT_LIMIT   = 8'd1;
    localparam logic [KeyW-1:0]  RST_TRIGGER_MASK = 16'd64;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_PREHEAT  = 5'b00010,
        PH_FEED     = 5'b00100,
        PH_INTERVAL = 5'b01000,
        PH_COOLDOWN = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [SpanW-1:0] preheat_time;
        logic [SpanW-1:0] feed_time;
        logic [SpanW-1:0] gap_time;
        logic [SpanW-1:0] cool_time;
        logic [ShotW-1:0] shot_limit;
        logic [KeyW-1:0]  trigger_mask;
    } t_cfg;

endpackage

// File: src/tbfs_cfg_regs.sv
// Configuration register file of the timed burst fire sequencer.
module tbfs_cfg_regs
    import tbfs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  logic [CfgIdxW-1:0]  i_index,
    input  logic [CfgDataW-1:0] i_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preheat_time <= RST_PREHEAT_TIME;
            r_cfg.feed_time    <= RST_FEED_TIME;
            r_cfg.gap_time     <= RST_GAP_TIME;
            r_cfg.cool_time    <= RST_COOL_TIME;
            r_cfg.shot_limit   <= RST_SHOT_LIMIT;
            r_cfg.trigger_mask <= RST_TRIGGER_MASK;
        end else if (i_wr) begin
            case (i_index)
                REG_PREHEAT_TIME: r_cfg.preheat_time <= i_data;
                REG_FEED_TIME:    r_cfg.feed_time    <= i_data;
                REG_GAP_TIME:     r_cfg.gap_time     <= i_data;
                REG_COOL_TIME:    r_cfg.cool_time    <= i_data;
                REG_SHOT_LIMIT:   r_cfg.shot_limit   <= i_data[ShotW-1:0];
                REG_TRIGGER_MASK: r_cfg.trigger_mask <= i_data;
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/tbfs_phase_ctrl.sv
// Phase state machine and enable decode of the timed burst fire sequencer.
module tbfs_phase_ctrl
    import tbfs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  t_cfg             i_cfg,
    input  logic             i_remote_valid,
    input  logic [KeyW-1:0]  i_key_bitmap,
    input  logic [TimeW-1:0] i_now_time,
    output logic             o_friction_on,
    output logic             o_feeder_on
);

    t_phase           r_phase, n_phase;
    logic             r_held, n_held;
    logic [TimeW-1:0] r_start, n_start;
    logic [ShotW-1:0] r_shots, n_shots;

    logic             pressed;
    logic             trig_edge;
    logic [TimeW-1:0] elapsed;
    logic [ShotW-1:0] shots_inc;

    always_comb begin
        pressed   = i_remote_valid && (|(i_key_bitmap & i_cfg.trigger_mask));
        trig_edge = pressed && !r_held;
        // wrap-safe elapsed time
        elapsed   = i_now_time - r_start;
        shots_inc = r_shots + {{(ShotW-1){1'b0}}, 1'b1};

        n_phase       = r_phase;
        n_held        = pressed;
        n_start       = r_start;
        n_shots       = r_shots;
        o_friction_on = 1'b0;
        o_feeder_on   = 1'b0;

        case (r_phase)
            PH_IDLE: begin
                if (trig_edge) begin
                    n_phase = PH_PREHEAT;
                    n_start = i_now_time;
                    n_shots = '0;
                end
            end
            PH_PREHEAT: begin
                o_friction_on = 1'b1;
                if (elapsed >= {{(TimeW-SpanW){1'b0}}, i_cfg.preheat_time}) begin
                    n_phase = PH_FEED;
                    n_start = i_now_time;
                end
            end
            PH_FEED: begin
                o_friction_on = 1'b1;
                o_feeder_on   = 1'b1;
                if (elapsed >= {{(TimeW-SpanW){1'b0}}, i_cfg.feed_time}) begin
                    n_shots = shots_inc;
                    n_phase = (shots_inc >= i_cfg.shot_limit) ? PH_COOLDOWN : PH_INTERVAL;
                    n_start = i_now_time;
                end
            end
            PH_INTERVAL: begin
                o_friction_on = 1'b1;
                if (elapsed >= {{(TimeW-SpanW){1'b0}}, i_cfg.gap_time}) begin
                    n_phase = PH_FEED;
                    n_start = i_now_time;
                end
            end
            PH_COOLDOWN: begin
                o_friction_on = 1'b1;
                // leave the phase start as it is
                if (elapsed >= {{(TimeW-SpanW){1'b0}}, i_cfg.cool_time}) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_held  = 1'b0;
                n_start = '0;
                n_shots = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 1'b0;
            r_start <= '0;
            r_shots <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_start <= n_start;
            r_shots <= n_shots;
        end
    end

endmodule

// File: src/timed_burst_fire_sequencer.sv
// Top level of the timed burst fire sequencer: input register, phase control, result register.
// Each request carries a remote-valid flag, a key bitmap and a millisecond time stamp and
// yields one result with the friction and feeder enables. A request is registered on
// acceptance and evaluated against the phase state once the result register is free or being
// emptied, which writes the state and the result register together, and a new request is
// taken every cycle while results are being taken. The input register keeps accepting while
// the result register still holds an untaken result, until both are full. Configuration writes
// are taken every cycle and apply to requests evaluated after them.
module timed_burst_fire_sequencer
    import tbfs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_remote_valid,
    input  logic [KeyW-1:0]     i_key_bitmap,
    input  logic [TimeW-1:0]    i_now_time,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_friction_on,
    output logic                o_feeder_on,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_cfg cfg;

    logic             r_in_vld;
    logic             r_remote;
    logic [KeyW-1:0]  r_keys;
    logic [TimeW-1:0] r_now;

    logic             r_out_vld;
    logic             r_fric;
    logic             r_feed;

    logic             step;
    logic             fric;
    logic             feed;

    assign o_cfg_ready = 1'b1;

    tbfs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // advance the held request whenever the result register is free or being emptied
    assign step    = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_remote <= i_remote_valid;
            r_keys   <= i_key_bitmap;
            r_now    <= i_now_time;
        end
    end

    tbfs_phase_ctrl u_phase (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_cfg          (cfg),
        .i_remote_valid (r_remote),
        .i_key_bitmap   (r_keys),
        .i_now_time     (r_now),
        .o_friction_on  (fric),
        .o_feeder_on    (feed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_fric <= fric;
            r_feed <= feed;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_friction_on = r_fric;
    assign o_feeder_on   = r_feed;

endmodule

// File: src/tbfs_checker.sv
// Port-level checker of the timed burst fire sequencer and its bind.
module tbfs_port_checker
    import tbfs_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_friction_on,
    input logic o_feeder_on,
    input logic o_cfg_ready
);

    // feeder never runs without the friction wheels
    a_feed_needs_fric: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_feeder_on || o_friction_on))
        else $error("feeder on without friction");

    // an empty result register lets the input side advance
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty result register");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_friction_on)
                                  && $stable(o_feeder_on)))
        else $error("stalled result changed");

    // no result without a request taken before it
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && !(i_valid && o_ready)) |=> ##1 !($rose(o_valid)))
        else $error("result without request");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind timed_burst_fire_sequencer tbfs_port_checker u_tbfs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_friction_on (o_friction_on),
    .o_feeder_on   (o_feeder_on),
    .o_cfg_ready   (o_cfg_ready)
);
